// File: sv/bcs_pkg.sv
// types, codes and microcode table of the battery charge supervisor
package bcs_pkg;

    typedef enum logic [1:0] {
        MODE_TICK       = 2'd0,
        MODE_FORCE_ON   = 2'd1,
        MODE_FORCE_OFF  = 2'd2,
        MODE_TOGGLE_AUTO = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        REG_START_PERCENT = 3'd0,
        REG_STOP_PERCENT  = 3'd1,
        REG_TEMP_LIMIT    = 3'd2,
        REG_EMPTY_CV      = 3'd3,
        REG_FULL_CV       = 3'd4,
        REG_VOLT_SCALE    = 3'd5,
        REG_TEMP_SCALE    = 3'd6
    } reg_idx_t;

    typedef logic [3:0] step_t;

    localparam step_t ST_IDLE     = 4'd0;
    localparam step_t ST_MUL_V    = 4'd1;
    localparam step_t ST_SCL_V    = 4'd2;
    localparam step_t ST_SCL_T    = 4'd3;
    localparam step_t ST_ACC_V    = 4'd4;
    localparam step_t ST_FIL_V    = 4'd5;
    localparam step_t ST_ACC_T    = 4'd6;
    localparam step_t ST_FIL_T    = 4'd7;
    localparam step_t ST_DIV_INIT = 4'd8;
    localparam step_t ST_DIV_STEP = 4'd9;
    localparam step_t ST_CTRL     = 4'd10;
    localparam step_t ST_OUT      = 4'd11;

    typedef enum logic [3:0] {
        UOP_IDLE,
        UOP_MUL_V,
        UOP_SCL_V,
        UOP_SCL_T,
        UOP_ACC_V,
        UOP_FIL_V,
        UOP_ACC_T,
        UOP_FIL_T,
        UOP_DIV_INIT,
        UOP_DIV_STEP,
        UOP_CTRL,
        UOP_OUT
    } uop_t;

    typedef enum logic [2:0] {
        COND_NEXT,
        COND_ACCEPT,
        COND_ZERO,
        COND_CLAMP,
        COND_LOOP,
        COND_DRAIN
    } ucond_t;

    typedef struct packed {
        uop_t   op;
        ucond_t cond;
        step_t  nxt;
        step_t  alt;
    } ucode_t;

    function automatic ucode_t ucode_rom(step_t step);
        ucode_t uc;
        unique case (step)
            ST_IDLE:     uc = '{op: UOP_IDLE,     cond: COND_ACCEPT, nxt: ST_MUL_V,    alt: ST_OUT};
            ST_MUL_V:    uc = '{op: UOP_MUL_V,    cond: COND_NEXT,   nxt: ST_SCL_V,    alt: ST_IDLE};
            ST_SCL_V:    uc = '{op: UOP_SCL_V,    cond: COND_NEXT,   nxt: ST_SCL_T,    alt: ST_IDLE};
            ST_SCL_T:    uc = '{op: UOP_SCL_T,    cond: COND_NEXT,   nxt: ST_ACC_V,    alt: ST_IDLE};
            ST_ACC_V:    uc = '{op: UOP_ACC_V,    cond: COND_NEXT,   nxt: ST_FIL_V,    alt: ST_IDLE};
            ST_FIL_V:    uc = '{op: UOP_FIL_V,    cond: COND_NEXT,   nxt: ST_ACC_T,    alt: ST_IDLE};
            ST_ACC_T:    uc = '{op: UOP_ACC_T,    cond: COND_NEXT,   nxt: ST_FIL_T,    alt: ST_IDLE};
            ST_FIL_T:    uc = '{op: UOP_FIL_T,    cond: COND_ZERO,   nxt: ST_DIV_INIT, alt: ST_CTRL};
            ST_DIV_INIT: uc = '{op: UOP_DIV_INIT, cond: COND_CLAMP,  nxt: ST_DIV_STEP, alt: ST_CTRL};
            ST_DIV_STEP: uc = '{op: UOP_DIV_STEP, cond: COND_LOOP,   nxt: ST_CTRL,     alt: ST_DIV_STEP};
            ST_CTRL:     uc = '{op: UOP_CTRL,     cond: COND_NEXT,   nxt: ST_OUT,      alt: ST_IDLE};
            ST_OUT:      uc = '{op: UOP_OUT,      cond: COND_DRAIN,  nxt: ST_IDLE,     alt: ST_IDLE};
            default:     uc = '{op: UOP_IDLE,     cond: COND_NEXT,   nxt: ST_IDLE,     alt: ST_IDLE};
        endcase
        return uc;
    endfunction

endpackage

// File: sv/battery_charge_supervisor.sv
// battery charge supervisor: microcoded filter, percent and switch control
// a command goes from accept straight to the output step; a tick runs the filter program, which
// skips the divider when percent is zero or the quotient reaches 128 and else runs the 7-step divider
// items are accepted only in the idle step, paced by the single shared multiplier and the
// one-bit-per-cycle divider; next item accepted while a result waits
// reset: synchronous active-low aresetn clears filters, flags and step counter, auto on
module battery_charge_supervisor
    import bcs_pkg::*;
#(
    parameter int ADC_BITS  = 10,
    parameter int FRAC_BITS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,  // voltage_sample, temp_sample, charge_sense_n, zero pad
    input  logic [1:0]  s_tuser,  // mode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // percent, voltage_centivolts, temp_decidegrees,
                                  // charging, switch_on, auto_on
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data
);

    localparam int VW      = 10 + FRAC_BITS;
    localparam int TW      = 9 + FRAC_BITS;
    localparam int PW      = VW + 17;
    localparam int SH      = 16 - FRAC_BITS;
    localparam int SHH     = (SH == 0) ? 0 : SH - 1;
    localparam int ADC_USE = (ADC_BITS < 10) ? ADC_BITS : 10;

    localparam logic [9:0]  ADC_MASK = 10'((11'd1 << ADC_USE) - 11'd1);
    localparam logic [PW:0] SCL_HALF = (SH == 0) ? '0 : ((PW + 1)'(1) << SHH);
    localparam logic [VW:0] HALF_V   = (VW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [TW+4:0] HALF_T = (TW + 5)'(1) << (FRAC_BITS - 1);

    // configuration
    logic [6:0]  start_pct_reg, stop_pct_reg;
    logic [8:0]  temp_limit_reg;
    logic [9:0]  empty_cv_reg, full_cv_reg;
    logic [16:0] volt_scale_reg, temp_scale_reg;

    // sequencer and state
    step_t       step_reg, step_next;
    ucode_t      uc;
    logic [2:0]  cnt_reg;
    logic        primed_reg, switch_reg, auto_reg, charging_reg;
    logic [6:0]  percent_reg;
    logic [VW-1:0] vf_reg, vs_reg;
    logic [TW-1:0] tf_reg, ts_reg;

    // datapath
    logic [9:0]  vraw_reg, traw_reg;
    logic        sense_n_reg;
    logic [PW-1:0] p_reg, prod;
    logic [PW:0] acc_reg;
    logic [9:0]  den_reg;
    logic [16:0] rem_reg, den_sh_reg;
    logic [6:0]  q_reg;

    logic [VW-1:0] mul_a;
    logic [16:0] mul_b;
    logic [PW:0] sc_full, fsum, fsum_sh;
    logic [VW-1:0] vs_sat, vf_flt;
    logic [TW-1:0] ts_sat, tf_flt;
    logic [9:0]  c_val, delta;
    logic        zero_pct, clamp_pct, s_fire;
    logic [16:0] p17;
    logic [6:0]  pct_new;
    logic        sw1, sw2, sw3;
    logic [VW:0] vr, vr_sh;
    logic [9:0]  vc_sat;
    logic [TW+4:0] tf10, tdr, td_sh;
    logic [11:0] td_sat;
    logic        m_tvalid_reg;
    logic [31:0] m_tdata_reg;
    logic        out_free;

    assign cfg_ready = 1'b1;
    assign uc        = ucode_rom(step_reg);
    assign s_tready  = (uc.op == UOP_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // shared multiplier operand select
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (uc.op)
            UOP_MUL_V: begin
                mul_a = VW'(vraw_reg);
                mul_b = volt_scale_reg;
            end
            UOP_SCL_V: begin
                mul_a = VW'(traw_reg);
                mul_b = temp_scale_reg;
            end
            UOP_SCL_T: begin
                mul_a = vs_reg;
                mul_b = 17'd51;
            end
            UOP_ACC_V: begin
                mul_a = vf_reg;
                mul_b = 17'd205;
            end
            UOP_FIL_V: begin
                mul_a = VW'(ts_reg);
                mul_b = 17'd77;
            end
            UOP_ACC_T: begin
                mul_a = VW'(tf_reg);
                mul_b = 17'd179;
            end
            UOP_FIL_T: begin
                mul_a = VW'(delta);
                mul_b = 17'd100;
            end
            default: ;
        endcase
    end

    assign prod    = PW'(mul_a) * PW'(mul_b);
    assign sc_full = ({1'b0, p_reg} + SCL_HALF) >> SH;
    assign vs_sat  = (|sc_full[PW:VW]) ? '1 : sc_full[VW-1:0];
    assign ts_sat  = (|sc_full[PW:TW]) ? '1 : sc_full[TW-1:0];
    assign fsum    = acc_reg + {1'b0, p_reg};
    assign fsum_sh = fsum >> 8;
    assign vf_flt  = fsum_sh[VW-1:0];
    assign tf_flt  = fsum_sh[TW-1:0];

    assign c_val     = vf_reg[FRAC_BITS +: 10];
    assign delta     = c_val - empty_cv_reg;
    assign zero_pct  = (full_cv_reg <= empty_cv_reg) || (c_val <= empty_cv_reg);
    assign p17       = p_reg[16:0];
    assign clamp_pct = (p17 >= {den_reg, 7'b0});

    assign pct_new = (q_reg > 7'd100) ? 7'd100 : q_reg;
    assign sw1 = (pct_new <= start_pct_reg) ? 1'b1 : switch_reg;
    assign sw2 = (pct_new >= stop_pct_reg) ? 1'b0 : sw1;
    assign sw3 = (tf_reg > {temp_limit_reg, {FRAC_BITS{1'b0}}}) ? 1'b0 : sw2;

    assign vr     = {1'b0, vf_reg} + HALF_V;
    assign vr_sh  = vr >> FRAC_BITS;
    assign vc_sat = (|vr_sh[VW:10]) ? 10'd1023 : vr_sh[9:0];
    assign tf10   = ((TW + 5)'(tf_reg) << 3) + ((TW + 5)'(tf_reg) << 1);
    assign tdr    = tf10 + HALF_T;
    assign td_sh  = tdr >> FRAC_BITS;
    assign td_sat = (|td_sh[TW+4:12]) ? 12'hFFF : td_sh[11:0];

    // next step
    always_comb begin
        step_next = uc.nxt;
        unique case (uc.cond)
            COND_NEXT:   step_next = uc.nxt;
            COND_ACCEPT: begin
                if (!s_fire) begin
                    step_next = step_reg;
                end else if (mode_t'(s_tuser) == MODE_TICK) begin
                    step_next = uc.nxt;
                end else begin
                    step_next = uc.alt;
                end
            end
            COND_ZERO:   step_next = zero_pct ? uc.alt : uc.nxt;
            COND_CLAMP:  step_next = clamp_pct ? uc.alt : uc.nxt;
            COND_LOOP:   step_next = (cnt_reg != 3'd0) ? uc.alt : uc.nxt;
            COND_DRAIN:  step_next = out_free ? uc.nxt : step_reg;
            default:     step_next = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg       <= ST_IDLE;
            start_pct_reg  <= 7'd20;
            stop_pct_reg   <= 7'd95;
            temp_limit_reg <= 9'd45;
            empty_cv_reg   <= 10'd300;
            full_cv_reg    <= 10'd420;
            volt_scale_reg <= 17'd64205;
            temp_scale_reg <= 17'd21141;
            primed_reg     <= 1'b0;
            switch_reg     <= 1'b0;
            auto_reg       <= 1'b1;
            charging_reg   <= 1'b0;
            percent_reg    <= '0;
            vf_reg         <= '0;
            tf_reg         <= '0;
            cnt_reg        <= '0;
            m_tvalid_reg   <= 1'b0;
        end else begin
            step_reg <= step_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    REG_START_PERCENT: start_pct_reg  <= cfg_data[6:0];
                    REG_STOP_PERCENT:  stop_pct_reg   <= cfg_data[6:0];
                    REG_TEMP_LIMIT:    temp_limit_reg <= cfg_data[8:0];
                    REG_EMPTY_CV:      empty_cv_reg   <= cfg_data[9:0];
                    REG_FULL_CV:       full_cv_reg    <= cfg_data[9:0];
                    REG_VOLT_SCALE:    volt_scale_reg <= cfg_data;
                    REG_TEMP_SCALE:    temp_scale_reg <= cfg_data;
                    default: ;
                endcase
            end
            if ((uc.op == UOP_OUT) && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            case (uc.op)
                UOP_IDLE: begin
                    if (s_fire) begin
                        case (mode_t'(s_tuser))
                            MODE_FORCE_ON:    switch_reg <= 1'b1;
                            MODE_FORCE_OFF:   switch_reg <= 1'b0;
                            MODE_TOGGLE_AUTO: auto_reg   <= !auto_reg;
                            default: ;
                        endcase
                    end
                end
                UOP_FIL_V: vf_reg <= primed_reg ? vf_flt : vs_reg;
                UOP_FIL_T: begin
                    tf_reg     <= primed_reg ? tf_flt : ts_reg;
                    primed_reg <= 1'b1;
                end
                UOP_DIV_INIT: cnt_reg <= 3'd6;
                UOP_DIV_STEP: cnt_reg <= cnt_reg - 3'd1;
                UOP_CTRL: begin
                    percent_reg  <= pct_new;
                    charging_reg <= switch_reg && !sense_n_reg;
                    if (auto_reg) begin
                        switch_reg <= sw3;
                    end
                end
                default: ;
            endcase
        end
    end

    // datapath payload
    always_ff @(posedge aclk) begin
        p_reg <= prod;
        case (uc.op)
            UOP_IDLE: begin
                if (s_fire) begin
                    vraw_reg    <= s_tdata[9:0] & ADC_MASK;
                    traw_reg    <= s_tdata[19:10] & ADC_MASK;
                    sense_n_reg <= s_tdata[20];
                end
            end
            UOP_SCL_V: vs_reg <= vs_sat;
            UOP_SCL_T: ts_reg <= ts_sat;
            UOP_ACC_V: acc_reg <= {1'b0, p_reg} + (PW + 1)'(128);
            UOP_ACC_T: acc_reg <= {1'b0, p_reg} + (PW + 1)'(128);
            UOP_FIL_T: begin
                den_reg <= full_cv_reg - empty_cv_reg;
                q_reg   <= '0;
            end
            UOP_DIV_INIT: begin
                rem_reg    <= p17;
                den_sh_reg <= {1'b0, den_reg, 6'b0};
                q_reg      <= clamp_pct ? 7'd100 : 7'd0;
            end
            UOP_DIV_STEP: begin
                if (rem_reg >= den_sh_reg) begin
                    rem_reg <= rem_reg - den_sh_reg;
                    q_reg   <= {q_reg[5:0], 1'b1};
                end else begin
                    q_reg   <= {q_reg[5:0], 1'b0};
                end
                den_sh_reg <= den_sh_reg >> 1;
            end
            UOP_OUT: begin
                if (out_free) begin
                    m_tdata_reg <= {auto_reg, switch_reg, charging_reg, td_sat, vc_sat,
                                    percent_reg};
                end
            end
            default: ;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        percent_reg <= 7'd100)
        else $error("percent out of range");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_tuser == MODE_TICK)) |=> (step_reg == ST_MUL_V))
        else $error("tick item did not start the filter program");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && (s_tuser != MODE_TICK)) |=> ($stable(vf_reg) && $stable(tf_reg)))
        else $error("command item changed a filter");

    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> ($past(step_reg) == ST_OUT))
        else $error("result raised outside the output step");

endmodule

// File: tb/sv/battery_charge_supervisor_test.sv
// self-checking testbench of the battery charge supervisor with its own predictor
module battery_charge_supervisor_test;
    import bcs_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int ADC = 10;
    localparam int FRAC = 8;
    localparam longint unsigned VOLT_CEIL = (64'd1024 << FRAC) - 1;
    localparam longint unsigned TEMP_CEIL = (64'd512 << FRAC) - 1;
    localparam longint unsigned HALF_LSB = 64'd1 << (FRAC - 1);
    localparam bit [2:0] REG_SPARE = 3'd7;
    localparam int STALL_LIMIT = 3000;
    localparam int ITEMS_PER_SEGMENT = 104;

    // fields from the lowest bit up: percent, voltage, temperature, charging, switch, auto
    typedef struct packed {
        bit        auto_on;
        bit        switch_on;
        bit        charging;
        bit [11:0] temp_dd;
        bit [9:0]  volt_cv;
        bit [6:0]  percent;
    } report_t;

    typedef bit [16:0] settings_t [7];

    class charge_tracker;
        bit [6:0]      start_pct, stop_pct;
        bit [8:0]      temp_limit;
        bit [9:0]      empty_cv, full_cv;
        bit [16:0]     volt_gain, temp_gain;
        bit [FRAC+9:0] volt_acc;
        bit [FRAC+8:0] temp_acc;
        bit [6:0]      level;
        bit            primed, switch_on, auto_on, charging;
        report_t       expected_reports[$];
        int            errors;

        function new();
            start_pct = 20;
            stop_pct = 95;
            temp_limit = 45;
            empty_cv = 300;
            full_cv = 420;
            volt_gain = 64205;
            temp_gain = 21141;
            volt_acc = 0;
            temp_acc = 0;
            level = 0;
            primed = 0;
            switch_on = 0;
            auto_on = 1;
            charging = 0;
            errors = 0;
        endfunction

        function void set_reg(bit [2:0] idx, bit [16:0] value);
            case (idx)
                REG_START_PERCENT: start_pct = value[6:0];
                REG_STOP_PERCENT:  stop_pct = value[6:0];
                REG_TEMP_LIMIT:    temp_limit = value[8:0];
                REG_EMPTY_CV:      empty_cv = value[9:0];
                REG_FULL_CV:       full_cv = value[9:0];
                REG_VOLT_SCALE:    volt_gain = value;
                REG_TEMP_SCALE:    temp_gain = value;
                default: ;
            endcase
        endfunction

        function longint unsigned scaled(bit [ADC-1:0] raw, bit [16:0] gain,
                                         longint unsigned ceiling);
            longint unsigned v;
            v = raw;
            v = (v * gain * 2 + (64'd1 << (16 - FRAC))) >> (17 - FRAC);
            return (v > ceiling) ? ceiling : v;
        endfunction

        function void note_item(mode_t mode, bit [9:0] volts, bit [9:0] temp, bit sense_n);
            longint unsigned vs, ts, c, pct, lim, vc, td;
            report_t want;
            case (mode)
                MODE_TICK: begin
                    vs = scaled(volts[ADC-1:0], volt_gain, VOLT_CEIL);
                    ts = scaled(temp[ADC-1:0], temp_gain, TEMP_CEIL);
                    if (!primed) begin
                        volt_acc = vs[FRAC+9:0];
                        temp_acc = ts[FRAC+8:0];
                        primed = 1'b1;
                    end else begin
                        vc = volt_acc;
                        td = temp_acc;
                        volt_acc = (FRAC + 10)'((51 * vs + 205 * vc + 128) >> 8);
                        temp_acc = (FRAC + 9)'((77 * ts + 179 * td + 128) >> 8);
                    end
                    c = volt_acc >> FRAC;
                    if (full_cv <= empty_cv || c <= empty_cv) begin
                        level = 0;
                    end else begin
                        pct = (c - empty_cv) * 100 / (full_cv - empty_cv);
                        level = (pct > 100) ? 7'd100 : pct[6:0];
                    end
                    charging = switch_on && !sense_n;
                    if (auto_on) begin
                        lim = temp_limit;
                        if (level <= start_pct && !switch_on)
                            switch_on = 1'b1;
                        if (level >= stop_pct && switch_on)
                            switch_on = 1'b0;
                        if (temp_acc > (lim << FRAC) && switch_on)
                            switch_on = 1'b0;
                    end
                end
                MODE_FORCE_ON:  switch_on = 1'b1;
                MODE_FORCE_OFF: switch_on = 1'b0;
                default:        auto_on = !auto_on;
            endcase
            vc = volt_acc;
            vc = (vc + HALF_LSB) >> FRAC;
            td = temp_acc;
            td = (td * 10 + HALF_LSB) >> FRAC;
            want.percent = level;
            want.volt_cv = (vc > 1023) ? 10'd1023 : vc[9:0];
            want.temp_dd = (td > 4095) ? 12'd4095 : td[11:0];
            want.charging = charging;
            want.switch_on = switch_on;
            want.auto_on = auto_on;
            expected_reports.push_back(want);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $display("%0t %s mismatch: expected %0d actual %0d", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_report(report_t got);
            report_t want;
            if (expected_reports.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            compare("percent", want.percent, got.percent);
            compare("voltage_centivolts", want.volt_cv, got.volt_cv);
            compare("temp_decidegrees", want.temp_dd, got.temp_dd);
            compare("charging", want.charging, got.charging);
            compare("switch_on", want.switch_on, got.switch_on);
            compare("auto_on", want.auto_on, got.auto_on);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;  // voltage_sample, temp_sample, charge_sense_n, zero pad
    logic [1:0]  s_tuser;  // mode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;  // percent, voltage_centivolts, temp_decidegrees,
                           // charging, switch_on, auto_on
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [16:0] cfg_data;

    charge_tracker tracker;
    int send_idle_pct, recv_idle_pct;
    int idle_cycles = 0;
    int volt_walk, temp_walk;
    bit stalled;

    battery_charge_supervisor #(
        .ADC_BITS(ADC),
        .FRAC_BITS(FRAC)
    ) dut (
        .aclk(aclk),
        .aresetn(aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #5ns aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready)
                tracker.set_reg(cfg_index, cfg_data);
            if (s_tvalid && s_tready)
                tracker.note_item(mode_t'(s_tuser), s_tdata[9:0], s_tdata[19:10], s_tdata[20]);
            if (m_tvalid && m_tready)
                tracker.check_report(report_t'(m_tdata));
        end
        if ((cfg_valid && cfg_ready) || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    task automatic send_item(mode_t mode, bit [9:0] volts, bit [9:0] temp, bit sense_n);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= mode;
        s_tdata <= {3'b000, sense_n, temp, volts};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    task automatic send_random_item();
        mode_t mode;
        bit [9:0] volts, temp;
        int pick;
        pick = $urandom_range(99);
        volt_walk += int'($urandom_range(30)) - 15;
        temp_walk += int'($urandom_range(10)) - 5;
        if (volt_walk < 150) volt_walk = 150;
        if (volt_walk > 600) volt_walk = 600;
        if (temp_walk < 40) temp_walk = 40;
        if (temp_walk > 250) temp_walk = 250;
        if (pick < 60) begin
            mode = MODE_TICK;
            volts = 10'(volt_walk + int'($urandom_range(20)) - 10);
            temp = 10'(temp_walk + int'($urandom_range(6)) - 3);
        end else if (pick < 80) begin
            mode = MODE_TICK;
            volts = 10'($urandom_range(1023));
            temp = 10'($urandom_range(1023));
        end else begin
            case ($urandom_range(2))
                0: mode = MODE_FORCE_ON;
                1: mode = MODE_FORCE_OFF;
                default: mode = MODE_TOGGLE_AUTO;
            endcase
            volts = 10'($urandom_range(1023));
            temp = 10'($urandom_range(1023));
        end
        send_item(mode, volts, temp, 1'($urandom_range(1)));
    endtask

    // wait for every pending result, then move on with the given idle rates
    task automatic settle(int send_pct, int recv_pct);
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (tracker.expected_reports.size() != 0);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        @(posedge aclk);
    endtask

    task automatic write_reg(bit [2:0] idx, bit [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    task automatic load_settings(settings_t vals, bit poke_spare);
        if (poke_spare)
            write_reg(REG_SPARE, 17'($urandom_range(17'h1FFFF)));
        write_reg(REG_START_PERCENT, vals[REG_START_PERCENT]);
        write_reg(REG_STOP_PERCENT, vals[REG_STOP_PERCENT]);
        write_reg(REG_TEMP_LIMIT, vals[REG_TEMP_LIMIT]);
        write_reg(REG_EMPTY_CV, vals[REG_EMPTY_CV]);
        write_reg(REG_FULL_CV, vals[REG_FULL_CV]);
        write_reg(REG_VOLT_SCALE, vals[REG_VOLT_SCALE]);
        write_reg(REG_TEMP_SCALE, vals[REG_TEMP_SCALE]);
        cfg_valid <= 1'b0;
    endtask

    function automatic settings_t pick_settings();
        settings_t s;
        if ($urandom_range(7) == 0) begin
            foreach (s[i]) s[i] = $urandom_range(1) ? 17'h1FFFF : 17'h0;
        end else begin
            s[REG_START_PERCENT] = 17'($urandom_range(0, 60));
            s[REG_STOP_PERCENT] = 17'($urandom_range(40, 100));
            s[REG_TEMP_LIMIT] = 17'($urandom_range(25, 70));
            s[REG_EMPTY_CV] = 17'($urandom_range(250, 350));
            s[REG_FULL_CV] = 17'($urandom_range(360, 460));
            s[REG_VOLT_SCALE] = 17'($urandom_range(55000, 75000));
            s[REG_TEMP_SCALE] = 17'($urandom_range(15000, 30000));
            foreach (s[i]) if ($urandom_range(9) == 0) s[i] = 17'($urandom_range(17'h1FFFF));
        end
        return s;
    endfunction

    initial begin
        tracker = new();
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = MODE_TICK;
        cfg_valid = 1'b0;
        cfg_index = REG_START_PERCENT;
        cfg_data = '0;
        send_idle_pct = 29;
        recv_idle_pct = 45;
        volt_walk = 350;
        temp_walk = 120;
        stalled = 1'b0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        fork
            begin
                // commands before the first tick report zeroed readings
                send_item(MODE_FORCE_ON, 10'd0, 10'd0, 1'b0);
                send_item(MODE_FORCE_OFF, 10'd1023, 10'd1023, 1'b1);
                send_item(MODE_TOGGLE_AUTO, 10'd0, 10'd0, 1'b0);
                send_item(MODE_TOGGLE_AUTO, 10'd0, 10'd0, 1'b0);
                // first tick loads the filters
                send_item(MODE_TICK, 10'd300, 10'd100, 1'b0);
                send_item(MODE_TICK, 10'd1023, 10'd1023, 1'b0);
                send_item(MODE_TICK, 10'd0, 10'd0, 1'b1);
                repeat (6) send_item(MODE_TICK, 10'd1023, 10'd60, 1'b0);
                send_item(MODE_TICK, 10'd1023, 10'd0, 1'b1);
                send_item(MODE_TOGGLE_AUTO, 10'd0, 10'd0, 1'b0);
                send_item(MODE_TICK, 10'd0, 10'd0, 1'b0);
                send_item(MODE_FORCE_ON, 10'd0, 10'd0, 1'b0);
                send_item(MODE_TICK, 10'd0, 10'd0, 1'b0);
                send_item(MODE_TOGGLE_AUTO, 10'd0, 10'd0, 1'b0);
                send_item(MODE_FORCE_OFF, 10'd0, 10'd0, 1'b0);
                // oversized register values get masked, scales saturate the samples
                settle(29, 45);
                load_settings('{17'h1FFFF, 17'h1FFFF, 17'h1FFFF, 17'h0, 17'h1FFFF,
                                17'h1FFFF, 17'h1FFFF}, 1'b1);
                send_item(MODE_TICK, 10'd1023, 10'd1023, 1'b0);
                send_item(MODE_TICK, 10'd1023, 10'd1023, 1'b1);
                // full not above empty forces zero percent
                settle(29, 45);
                load_settings('{17'd0, 17'd0, 17'd0, 17'd500, 17'd500,
                                17'd64205, 17'd0}, 1'b0);
                send_item(MODE_TICK, 10'd1023, 10'd512, 1'b0);
                send_item(MODE_TICK, 10'd0, 10'd0, 1'b0);
                for (int phase = 0; phase < 3; phase++) begin
                    for (int seg = 0; seg < 4; seg++) begin
                        case (phase)
                            0: settle(29, 45);
                            1: settle(45, 29);
                            default: settle(0, 0);
                        endcase
                        load_settings(pick_settings(), $urandom_range(7) == 0);
                        repeat (ITEMS_PER_SEGMENT) send_random_item();
                    end
                end
                settle(0, 0);
                repeat (20) @(posedge aclk);
            end
            begin
                wait (idle_cycles >= STALL_LIMIT);
                stalled = 1'b1;
            end
        join_any
        if (tracker.expected_reports.size() != 0)
            $display("%0t results never arrived: expected %0d actual 0", $time,
                     tracker.expected_reports.size());
        if (!stalled && tracker.errors == 0 && tracker.expected_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
